// ===== design/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants, register map and controller/datapath interface types.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int LEN_BITS        = 7;
  localparam int MEDIAN_BITS     = 32;
  localparam int PADDR_BITS      = 3;
  localparam int PDATA_BITS      = 32;

  localparam logic REG_IDX_WINDOW_LEN = 1'b0;
  localparam logic [LEN_BITS-1:0] WINDOW_LEN_RESET = LEN_BITS'(1);

  typedef struct packed {
    logic accept;
    logic hist_rd;
    logic load_oldest;
    logic rm_rd;
    logic rm_eval;
    logic ins_init;
    logic ins_rd;
    logic ins_eval;
    logic hist_wr;
    logic med_rd;
    logic load_out;
  } swm_cmd_t;

  typedef struct packed {
    logic window_full;
    logic last_rm;
    logic idx_zero;
    logic greater;
    logic result;
    logic out_free;
  } swm_status_t;

endpackage

// ===== design/sliding_window_median.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median filter over the last window_len samples.
//
// Input channel sample_valid_i/sample_ready_o carries one unsigned sample per
// beat; output channel median_valid_o/median_ready_i carries the lower median
// of the full window. The first window_len-1 samples after reset or after a
// write of window_len give no beat; every later sample gives one.
// The block works on one sample at a time. A sample in the filling phase
// walks the sorted-window RAM once to insert; with a full window the work
// is set by the single read port of that RAM, which is walked once to evict
// the oldest sample and once to insert the new.
// The median is registered; a stalled receiver holds it, and a new sample is
// taken meanwhile until its own result needs the output register.
// Reset clears the counters and sets window_len to 1; RAM contents are not
// cleared and only entries written since the last restart are read.
// Write window_len (APB byte address 0) only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_median #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swm_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [swm_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [swm_pkg::PDATA_BITS-1:0]  prdata,
  output logic                            pready,
  input  logic                            sample_valid_i,
  output logic                            sample_ready_o,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  output logic                            median_valid_o,
  input  logic                            median_ready_i,
  output logic [swm_pkg::MEDIAN_BITS-1:0] median_o
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic [swm_pkg::LEN_BITS-1:0] window_len_q;
  logic                         reg_sel;
  logic                         cfg_wr;
  logic [CNT_W-1:0]             k_eff;
  swm_pkg::swm_cmd_t            cmd;
  swm_pkg::swm_status_t         status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == swm_pkg::REG_IDX_WINDOW_LEN);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? swm_pkg::PDATA_BITS'(window_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= swm_pkg::WINDOW_LEN_RESET;
    end else if (cfg_wr) begin
      window_len_q <= pwdata[swm_pkg::LEN_BITS-1:0];
    end
  end

  always_comb begin
    if (window_len_q == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(window_len_q) > WINDOW_MAX) begin
      k_eff = CNT_W'(WINDOW_MAX);
    end else begin
      k_eff = CNT_W'(window_len_q);
    end
  end

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_valid_i),
    .in_ready_o (sample_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swm_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .k_i            (k_eff),
    .restart_i      (cfg_wr),
    .sample_i       (sample_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .median_valid_o (median_valid_o),
    .median_ready_i (median_ready_i),
    .median_o       (median_o)
  );

endmodule

// ===== design/swm_ram.sv =====
// ----------------------------------------------------------------------------
// swm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer: evict the oldest sample (full window only), insert the new one,
// read the median when a result is due.
module swm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swm_pkg::swm_status_t status_i,
  output swm_pkg::swm_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_HRD   = 10'b00_0000_0010,
    S_HLD   = 10'b00_0000_0100,
    S_RRD   = 10'b00_0000_1000,
    S_REVAL = 10'b00_0001_0000,
    S_INIT  = 10'b00_0010_0000,
    S_IRD   = 10'b00_0100_0000,
    S_IEVAL = 10'b00_1000_0000,
    S_HWR   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.window_full ? S_HRD : S_INIT;
        end
      end
      S_HRD: begin
        cmd_o.hist_rd = 1'b1;
        state_d = S_HLD;
      end
      S_HLD: begin
        cmd_o.load_oldest = 1'b1;
        state_d = S_RRD;
      end
      S_RRD: begin
        cmd_o.rm_rd = 1'b1;
        state_d = S_REVAL;
      end
      S_REVAL: begin
        cmd_o.rm_eval = 1'b1;
        state_d = status_i.last_rm ? S_INIT : S_RRD;
      end
      S_INIT: begin
        cmd_o.ins_init = 1'b1;
        state_d = S_IRD;
      end
      S_IRD: begin
        cmd_o.ins_rd = 1'b1;
        state_d = status_i.idx_zero ? S_HWR : S_IEVAL;
      end
      S_IEVAL: begin
        cmd_o.ins_eval = 1'b1;
        state_d = status_i.greater ? S_IRD : S_HWR;
      end
      S_HWR: begin
        cmd_o.hist_wr = 1'b1;
        cmd_o.med_rd  = status_i.result;
        state_d = status_i.result ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== design/swm_dp.sv =====
// ----------------------------------------------------------------------------
// swm_dp
// Datapath: history ring, sorted window, counters and the result register.
// ----------------------------------------------------------------------------
module swm_dp #(
  parameter int  WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int  SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [CNT_W-1:0]               k_i,
  input  logic                           restart_i,
  input  logic [SAMPLE_BITS-1:0]         sample_i,
  input  swm_pkg::swm_cmd_t              cmd_i,
  output swm_pkg::swm_status_t           status_o,
  output logic                           median_valid_o,
  input  logic                           median_ready_i,
  output logic [swm_pkg::MEDIAN_BITS-1:0] median_o
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] oldest_q;
  logic [SAMPLE_BITS-1:0] median_q;
  logic                   found_q;
  logic                   full_q;
  logic                   out_valid_q;
  logic [IDX_W-1:0]       idx_q;
  logic [IDX_W-1:0]       wp_q;
  logic [CNT_W-1:0]       fill_q;

  logic [IDX_W-1:0]       km1_idx;
  logic [IDX_W-1:0]       med_idx;
  logic [IDX_W-1:0]       wp_fix;
  logic [CNT_W-1:0]       wp_inc;
  logic                   last_rm;

  logic                   s_we, s_re, h_we, h_re;
  logic [IDX_W-1:0]       s_waddr, s_raddr;
  logic [SAMPLE_BITS-1:0] s_wdata, s_rdata, h_rdata;

  assign km1_idx = IDX_W'(k_i - CNT_W'(1));
  assign med_idx = km1_idx >> 1;
  assign wp_fix  = (CNT_W'(wp_q) >= k_i) ? '0 : wp_q;
  assign wp_inc  = CNT_W'(wp_q) + CNT_W'(1);
  assign last_rm = (idx_q == km1_idx);

  assign status_o.window_full = (fill_q >= k_i);
  assign status_o.last_rm     = last_rm;
  assign status_o.idx_zero    = (idx_q == '0);
  assign status_o.greater     = (s_rdata > sample_q);
  assign status_o.result      = full_q || ((fill_q + CNT_W'(1)) == k_i);
  assign status_o.out_free    = !out_valid_q || median_ready_i;

  always_comb begin
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_waddr = idx_q;
    s_raddr = idx_q;
    s_wdata = sample_q;
    if (cmd_i.rm_rd) begin
      s_re = 1'b1;
    end
    if (cmd_i.rm_eval && found_q) begin
      s_we    = 1'b1;
      s_waddr = IDX_W'(idx_q - IDX_W'(1));
      s_wdata = s_rdata;
    end
    if (cmd_i.ins_rd) begin
      if (idx_q == '0) begin
        s_we = 1'b1;
      end else begin
        s_re    = 1'b1;
        s_raddr = IDX_W'(idx_q - IDX_W'(1));
      end
    end
    if (cmd_i.ins_eval) begin
      s_we    = 1'b1;
      s_wdata = status_o.greater ? s_rdata : sample_q;
    end
    if (cmd_i.med_rd) begin
      s_re    = 1'b1;
      s_raddr = med_idx;
    end
  end

  assign h_we = cmd_i.hist_wr;
  assign h_re = cmd_i.hist_rd;

  swm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_sorted (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  swm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (wp_q),
    .wdata_i (sample_q),
    .re_i    (h_re),
    .raddr_i (wp_q),
    .rdata_o (h_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.load_oldest) begin
      oldest_q <= h_rdata;
    end
    if (cmd_i.load_out) begin
      median_q <= s_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
    end else begin
      if (cmd_i.accept) begin
        full_q <= status_o.window_full;
        wp_q   <= wp_fix;
      end
      if (cmd_i.load_oldest) begin
        found_q <= 1'b0;
        idx_q   <= '0;
      end
      if (cmd_i.rm_eval) begin
        if (!found_q && (s_rdata == oldest_q)) begin
          found_q <= 1'b1;
        end
        idx_q <= IDX_W'(idx_q + IDX_W'(1));
      end
      if (cmd_i.ins_init) begin
        idx_q <= full_q ? km1_idx : IDX_W'(fill_q);
      end
      if (cmd_i.ins_eval && status_o.greater) begin
        idx_q <= IDX_W'(idx_q - IDX_W'(1));
      end
      if (cmd_i.hist_wr) begin
        wp_q <= (wp_inc >= k_i) ? '0 : IDX_W'(wp_inc);
        if (!full_q) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
      if (restart_i) begin
        fill_q <= '0;
        wp_q   <= '0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (median_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign median_valid_o = out_valid_q;
  assign median_o       = swm_pkg::MEDIAN_BITS'(median_q);

`ifndef ASSERT_OFF
  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || median_ready_i))
    else $error("result register overwritten while a beat is pending");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k_i)
    else $error("fill count above window length");

  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(wp_q) < k_i)
    else $error("write pointer outside the window");

  a_evict_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rm_eval && last_rm) |-> (found_q || (s_rdata == oldest_q)))
    else $error("evicted sample missing from the sorted window");
`endif

endmodule
